@@ rtl/core/pedal_speed_ramp_drive_defines.svh @@
// Assertion macros shared by the pedal speed ramp drive RTL.
`ifndef PEDAL_SPEED_RAMP_DRIVE_DEFINES_SVH
`define PEDAL_SPEED_RAMP_DRIVE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define PSRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define PSRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/psrd_pkg.sv @@
// Package with the types and constants of the pedal speed ramp drive.
package psrd_pkg;

  typedef enum logic [1:0] {
    CFG_FWD_LIMIT = 2'd0,
    CFG_BWD_LIMIT = 2'd1,
    CFG_FWD_FLOOR = 2'd2,
    CFG_BWD_FLOOR = 2'd3
  } cfg_idx_e;

  typedef logic signed [14:0] speed_t;
  typedef logic signed [15:0] speed_wide_t;

  localparam int unsigned PCT_W = 7;
  localparam int unsigned MAG_W = 14;
  localparam int unsigned MS_W = 8;
  localparam int unsigned CFG_W = 14;
  localparam int unsigned BLINK_W = 9;
  localparam int unsigned PCT_SCALE_W = 23;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [MAG_W-1:0] SPEED_FULL = 14'd10000;
  localparam logic [MAG_W-1:0] SPEED_HALF = 14'd5000;

  localparam logic [PCT_W-1:0] FWD_LIMIT_RST = 7'd60;
  localparam logic [PCT_W-1:0] BWD_LIMIT_RST = 7'd35;
  localparam logic [MAG_W-1:0] FWD_FLOOR_RST = 14'd1500;
  localparam logic [MAG_W-1:0] BWD_FLOOR_RST = 14'd1000;

  // floor(x / 100) is (x * PCT_RECIP) >> PCT_SHIFT for every x below 40000.
  localparam logic [15:0] PCT_RECIP = 16'd41944;
  localparam int unsigned PCT_SHIFT = 22;

  // floor(x / 10000) is (x * DUTY_RECIP) >> DUTY_SHIFT for every x below 2^30.
  localparam int unsigned DUTY_RECIP_W = 31;
  localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP = 31'd1759218605;
  localparam int unsigned DUTY_SHIFT = 44;

  localparam logic [5:0] RAMP_UP = 6'd50;
  localparam logic [5:0] BRAKE_FAST = 6'd8;
  localparam logic [5:0] BRAKE_SLOW = 6'd4;
  localparam speed_wide_t BRAKE_KNEE = 16'sd5000;

  localparam logic [MAG_W-1:0] BLINK_KNEE_LOW = 14'd2000;
  localparam logic [MAG_W-1:0] BLINK_KNEE_HIGH = 14'd5000;
  localparam logic [BLINK_W-1:0] BLINK_STOP = 9'd500;
  localparam logic [BLINK_W-1:0] BLINK_SLOW = 9'd250;
  localparam logic [BLINK_W-1:0] BLINK_MID = 9'd125;
  localparam logic [BLINK_W-1:0] BLINK_FAST = 9'd60;

endpackage

@@ rtl/core/pedal_speed_ramp_drive.sv @@
// Pedal speed ramp drive: pedal target, speed ramp, PWM duties and blink rate.
// An item passes the input register, then the output register (the held speed).
// Throughput is one item per cycle while out_stall_i is low. The target is formed as an
// item enters the input register; the ramp and duty scaling run as it moves to the output
// register. Reset clears the speed to zero and loads the default limits and floors.
`include "pedal_speed_ramp_drive_defines.svh"

module pedal_speed_ramp_drive #(
  parameter int unsigned DUTY_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [psrd_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         stop_request_i,
  input  logic [psrd_pkg::PCT_W-1:0]   forward_pedal_i,
  input  logic [psrd_pkg::PCT_W-1:0]   backward_pedal_i,
  input  logic [psrd_pkg::MS_W-1:0]    elapsed_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output psrd_pkg::speed_t             speed_out_o,
  output logic [DUTY_BITS-1:0]         forward_duty_o,
  output logic [DUTY_BITS-1:0]         backward_duty_o,
  output logic [psrd_pkg::BLINK_W-1:0] blink_half_period_o
);
  import psrd_pkg::*;

  localparam int unsigned NUM_W = MAG_W + DUTY_BITS;
  localparam int unsigned PROD_W = NUM_W + DUTY_RECIP_W;
  localparam int unsigned SCALE_PROD_W = PCT_SCALE_W + PCT_W;

  logic [PCT_W-1:0]       fwd_limit_q, bwd_limit_q;
  logic [PCT_SCALE_W-1:0] fwd_scale_q, bwd_scale_q;
  logic [MAG_W-1:0]       fwd_floor_q, bwd_floor_q;
  logic [PCT_W-1:0]       wr_limit;
  logic [MAG_W-1:0]       wr_floor;

  logic                   in_valid_q;
  logic                   in_stop_q;
  speed_t                 in_target_q;
  logic [MS_W-1:0]        in_ms_q;
  logic                   in_take;
  logic                   advance;

  logic                   out_valid_q;
  speed_t                 speed_q;
  logic [DUTY_BITS-1:0]   fwd_duty_q, bwd_duty_q;
  logic [BLINK_W-1:0]     blink_q;

  logic                   fwd_pressed, bwd_pressed;
  logic [PCT_SCALE_W-1:0] sel_scale;
  logic [PCT_W-1:0]       sel_limit;
  logic [PCT_W-1:0]       sel_pedal;
  logic [SCALE_PROD_W-1:0] share_prod;
  logic [PCT_W-1:0]       share_pct;
  logic [MAG_W-1:0]       share_mag;
  speed_t                 target_d;

  speed_wide_t            cur, tgt, ffl, bfl;
  speed_wide_t            up_step, fast_step, slow_step;
  speed_wide_t            ramp, next;
  speed_t                 speed_d;
  speed_t                 speed_abs;
  logic [MAG_W-1:0]       mag;
  logic [NUM_W-1:0]       duty_num;
  logic [PROD_W-1:0]      duty_prod;
  logic [DUTY_BITS-1:0]   duty;
  logic [BLINK_W-1:0]     blink_d;

  // Configuration writes, saturated to range; the limit's reciprocal scale is kept beside it.
  assign wr_limit = (cfg_wdata_i[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : cfg_wdata_i[PCT_W-1:0];
  assign wr_floor = (cfg_wdata_i > SPEED_FULL) ? SPEED_FULL : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_limit_q <= FWD_LIMIT_RST;
      bwd_limit_q <= BWD_LIMIT_RST;
      fwd_scale_q <= PCT_SCALE_W'(PCT_SCALE_W'(FWD_LIMIT_RST) * PCT_SCALE_W'(PCT_RECIP));
      bwd_scale_q <= PCT_SCALE_W'(PCT_SCALE_W'(BWD_LIMIT_RST) * PCT_SCALE_W'(PCT_RECIP));
      fwd_floor_q <= FWD_FLOOR_RST;
      bwd_floor_q <= BWD_FLOOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FWD_LIMIT: begin
          fwd_limit_q <= wr_limit;
          fwd_scale_q <= PCT_SCALE_W'(PCT_SCALE_W'(wr_limit) * PCT_SCALE_W'(PCT_RECIP));
        end
        CFG_BWD_LIMIT: begin
          bwd_limit_q <= wr_limit;
          bwd_scale_q <= PCT_SCALE_W'(PCT_SCALE_W'(wr_limit) * PCT_SCALE_W'(PCT_RECIP));
        end
        CFG_FWD_FLOOR: fwd_floor_q <= wr_floor;
        CFG_BWD_FLOOR: bwd_floor_q <= wr_floor;
      endcase
    end
  end

  // Handshake between the input register and the result register.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // Target speed from the pedals, formed as the item is taken in.
  always_comb begin
    fwd_pressed = |forward_pedal_i;
    bwd_pressed = |backward_pedal_i;
    sel_scale   = fwd_pressed ? fwd_scale_q : bwd_scale_q;
    sel_limit   = fwd_pressed ? fwd_limit_q : bwd_limit_q;
    sel_pedal   = fwd_pressed ? forward_pedal_i : backward_pedal_i;
    share_prod  = SCALE_PROD_W'(sel_scale) * SCALE_PROD_W'(sel_pedal);
    share_pct   = share_prod[PCT_SHIFT +: PCT_W];
    if (share_pct > sel_limit) begin
      share_pct = sel_limit;
    end
    share_mag = MAG_W'(share_pct) * MAG_W'(PCT_MAX);
    if (fwd_pressed == bwd_pressed) begin
      target_d = '0;
    end else if (fwd_pressed) begin
      target_d = speed_t'({1'b0, share_mag});
    end else begin
      target_d = -speed_t'({1'b0, share_mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_stop_q   <= stop_request_i;
      in_target_q <= target_d;
      in_ms_q     <= elapsed_ms_i;
    end
  end

  // Speed ramp toward the target, with snaps inside the deadbands.
  always_comb begin
    cur       = speed_wide_t'(speed_q);
    tgt       = speed_wide_t'(in_target_q);
    ffl       = speed_wide_t'({2'b00, fwd_floor_q});
    bfl       = speed_wide_t'({2'b00, bwd_floor_q});
    up_step   = speed_wide_t'(16'(in_ms_q) * 16'(RAMP_UP));
    fast_step = speed_wide_t'(16'(in_ms_q) * 16'(BRAKE_FAST));
    slow_step = speed_wide_t'(16'(in_ms_q) * 16'(BRAKE_SLOW));
    ramp      = cur;
    next      = tgt;
    if (cur < tgt) begin
      if (cur < 16'sd0 && cur > -bfl) begin
        next = '0;
      end else if (cur > 16'sd0 && cur < ffl) begin
        next = ffl;
      end else begin
        if (cur < 16'sd0) begin
          ramp = cur + ((cur < -BRAKE_KNEE) ? fast_step : slow_step);
        end else begin
          ramp = cur + up_step;
        end
        next = (ramp > tgt) ? tgt : ramp;
      end
    end else if (cur > tgt) begin
      if (cur > 16'sd0 && cur < ffl) begin
        next = '0;
      end else if (cur < 16'sd0 && cur > -bfl) begin
        next = -bfl;
      end else begin
        if (cur > 16'sd0) begin
          ramp = cur - ((cur > BRAKE_KNEE) ? fast_step : slow_step);
        end else begin
          ramp = cur - up_step;
        end
        next = (ramp < tgt) ? tgt : ramp;
      end
    end
    speed_d = in_stop_q ? '0 : next[14:0];
  end

  // One duty scaler serves both directions, since only one side is ever nonzero.
  always_comb begin
    speed_abs = speed_d[14] ? -speed_d : speed_d;
    mag       = speed_abs[MAG_W-1:0];
    duty_num  = (NUM_W'(mag) << DUTY_BITS) - NUM_W'(mag) + NUM_W'(SPEED_HALF);
    duty_prod = PROD_W'(duty_num) * PROD_W'(DUTY_RECIP);
    duty      = duty_prod[DUTY_SHIFT +: DUTY_BITS];
    if (mag == '0) begin
      blink_d = BLINK_STOP;
    end else if (mag < BLINK_KNEE_LOW) begin
      blink_d = BLINK_SLOW;
    end else if (mag < BLINK_KNEE_HIGH) begin
      blink_d = BLINK_MID;
    end else begin
      blink_d = BLINK_FAST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      speed_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      speed_q     <= speed_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_duty_q <= speed_d[14] ? '0 : duty;
      bwd_duty_q <= speed_d[14] ? duty : '0;
      blink_q    <= blink_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign speed_out_o         = speed_q;
  assign forward_duty_o      = fwd_duty_q;
  assign backward_duty_o     = bwd_duty_q;
  assign blink_half_period_o = blink_q;

  `PSRD_ASSERT(a_speed_range,
    !out_valid_q || (speed_q <= 15'sd10000 && speed_q >= -15'sd10000), "speed left its range")
  `PSRD_ASSERT(a_one_duty,
    !out_valid_q || fwd_duty_q == '0 || bwd_duty_q == '0, "both PWM duties are active")
  `PSRD_ASSERT(a_blink_stop, !out_valid_q || ((speed_q == '0) == (blink_q == BLINK_STOP)),
    "blink rate disagrees with speed")
  `PSRD_ASSERT_NEXT(a_stop_zero, advance && in_stop_q, speed_q == '0,
    "stop request left speed nonzero")
  `PSRD_ASSERT(a_no_stall_empty, out_valid_q || !in_stall_o,
    "input stalled with an empty result register")

endmodule
